>>> rtl/core/undirected_graph_cycle_detect_assert.svh
// Assertion macros for the cycle detector; clocked on clk_i, off while rst_ni is low.
`ifndef UNDIRECTED_GRAPH_CYCLE_DETECT_ASSERT_SVH
`define UNDIRECTED_GRAPH_CYCLE_DETECT_ASSERT_SVH
`ifndef SYNTH
`define UGCD_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define UGCD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define UGCD_ASSERT(label, expr, msg)
`define UGCD_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

>>> rtl/core/ugcd_pkg.sv
package ugcd_pkg;

  localparam int NODES   = 64;
  localparam int ID_W    = $clog2(NODES);
  localparam int IN_ID_W = 10;

  // queue depth, power of two so the pointers wrap naturally
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [NODES-1:0] row_t;

  typedef enum logic [1:0] {
    K_EDGE  = 2'd0,
    K_CLEAR = 2'd1,
    K_RANGE = 2'd2
  } req_kind_e;

  typedef struct packed {
    req_kind_e kind;
    id_t       a;
    id_t       b;
  } ugcd_entry_t;

  typedef struct packed {
    logic        valid;
    ugcd_entry_t entry;
  } ugcd_q_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
  } ugcd_qstat_t;

  typedef struct packed {
    logic cycle;
    logic clearing;
  } ugcd_bstat_t;

endpackage

>>> rtl/core/ugcd_front.sv
module ugcd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [9:0]           from_node_i,
  input  logic [9:0]           to_node_i,
  output ugcd_pkg::ugcd_q_t     q_o,
  input  logic                 q_pop_i,
  output ugcd_pkg::ugcd_qstat_t status_o
);
  import ugcd_pkg::*;

  ugcd_entry_t       mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  ugcd_entry_t       ent;
  logic              push, pop, full, bad_range;

  // range check on ids zero-extended one bit wider than the inputs
  assign bad_range = ({1'b0, from_node_i} >= (IN_ID_W + 1)'(NODES)) ||
                     ({1'b0, to_node_i}   >= (IN_ID_W + 1)'(NODES));

  always_comb begin
    ent.a = from_node_i[ID_W-1:0];
    ent.b = to_node_i[ID_W-1:0];
    if (req_type_i == REQ_CLEAR) begin
      ent.kind = K_CLEAR;
    end else if (bad_range) begin
      ent.kind = K_RANGE;
    end else begin
      ent.kind = K_EDGE;
    end
  end

  assign full       = (cnt_q == QCNT_W'(QDEPTH));
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;
  assign pop        = q_pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= ent;
    end
  end

  assign q_o.valid       = (cnt_q != '0);
  assign q_o.entry       = mem_q[rd_ptr_q];
  assign status_o.count  = cnt_q;
  assign status_o.full   = full;

endmodule

>>> rtl/core/ugcd_back.sv
module ugcd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ugcd_pkg::ugcd_q_t     q_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 cycle_found_o,
  output logic                 edge_was_new_o,
  output logic                 range_error_o,
  output ugcd_pkg::ugcd_bstat_t status_o
);
  import ugcd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_ROWB = 3'd2;
  localparam logic [2:0] S_FNDA = 3'd3;
  localparam logic [2:0] S_FNDB = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state_q, state_d;
  logic       cycle_q, cycle_d;
  logic       out_valid_q, out_valid_d;
  row_t       row_valid_q;
  row_t       par_valid_q;

  id_t  a_q, a_d, b_q, b_d, cur_q, cur_d, ra_q, ra_d;
  logic res_new_q, res_new_d, res_rng_q, res_rng_d;
  logic cyc_out_q, new_out_q, rng_out_q, load_out;

  // adjacency rows and component parents
  row_t adj_mem [NODES];
  id_t  par_mem [NODES];
  row_t adj_rd_q, adj_wd, row_eff;
  id_t  par_rd_q, par_wd, par_wa, adj_ra, adj_wa, p_eff;
  logic rowv_rd_q, parv_rd_q;
  logic adj_we, par_we, clr, rowv_set;
  id_t  rowv_idx;

  assign row_eff = rowv_rd_q ? adj_rd_q : '0;
  assign p_eff   = parv_rd_q ? par_rd_q : cur_q;

  always_comb begin
    state_d     = state_q;
    cycle_d     = cycle_q;
    a_d         = a_q;
    b_d         = b_q;
    cur_d       = cur_q;
    ra_d        = ra_q;
    res_new_d   = res_new_q;
    res_rng_d   = res_rng_q;
    q_pop_o     = 1'b0;
    clr         = 1'b0;
    adj_ra      = a_q;
    adj_we      = 1'b0;
    adj_wa      = a_q;
    adj_wd      = row_eff;
    rowv_set    = 1'b0;
    rowv_idx    = a_q;
    par_we      = 1'b0;
    par_wa      = a_q;
    par_wd      = a_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (q_i.valid) begin
          q_pop_o   = 1'b1;
          a_d       = q_i.entry.a;
          b_d       = q_i.entry.b;
          res_new_d = 1'b0;
          res_rng_d = 1'b0;
          case (q_i.entry.kind)
            K_CLEAR: begin
              clr     = 1'b1;
              cycle_d = 1'b0;
              state_d = S_EMIT;
            end
            K_RANGE: begin
              res_rng_d = 1'b1;
              state_d   = S_EMIT;
            end
            K_EDGE: begin
              adj_ra  = q_i.entry.a;
              state_d = S_CHK;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CHK: begin
        if (row_eff[b_q]) begin
          state_d = S_EMIT;
        end else begin
          res_new_d = 1'b1;
          adj_we    = 1'b1;
          adj_wa    = a_q;
          adj_wd    = row_eff | (row_t'(1) << b_q);
          rowv_set  = 1'b1;
          rowv_idx  = a_q;
          if (a_q == b_q) begin
            cycle_d = 1'b1;
            state_d = S_EMIT;
          end else begin
            adj_ra  = b_q;
            state_d = S_ROWB;
          end
        end
      end
      S_ROWB: begin
        adj_we   = 1'b1;
        adj_wa   = b_q;
        adj_wd   = row_eff | (row_t'(1) << a_q);
        rowv_set = 1'b1;
        rowv_idx = b_q;
        cur_d    = a_q;
        state_d  = S_FNDA;
      end
      S_FNDA: begin
        if (p_eff == cur_q) begin
          ra_d    = cur_q;
          cur_d   = b_q;
          state_d = S_FNDB;
        end else begin
          cur_d = p_eff;
        end
      end
      S_FNDB: begin
        if (p_eff == cur_q) begin
          state_d = S_EMIT;
          if (ra_q == cur_q) begin
            cycle_d = 1'b1;
          end else if (ra_q < cur_q) begin
            par_we = 1'b1;
            par_wa = cur_q;
            par_wd = ra_q;
          end else begin
            par_we = 1'b1;
            par_wa = ra_q;
            par_wd = cur_q;
          end
        end else begin
          cur_d = p_eff;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cycle_q     <= 1'b0;
      out_valid_q <= 1'b0;
      row_valid_q <= '0;
      par_valid_q <= '0;
    end else begin
      state_q     <= state_d;
      cycle_q     <= cycle_d;
      out_valid_q <= out_valid_d;
      if (clr) begin
        row_valid_q <= '0;
        par_valid_q <= '0;
      end else begin
        if (rowv_set) begin
          row_valid_q[rowv_idx] <= 1'b1;
        end
        if (par_we) begin
          par_valid_q[par_wa] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    cur_q     <= cur_d;
    ra_q      <= ra_d;
    res_new_q <= res_new_d;
    res_rng_q <= res_rng_d;
    if (load_out) begin
      cyc_out_q <= cycle_q;
      new_out_q <= res_new_q;
      rng_out_q <= res_rng_q;
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    adj_rd_q  <= adj_mem[adj_ra];
    rowv_rd_q <= row_valid_q[adj_ra];
  end

  always_ff @(posedge clk_i) begin
    if (par_we) begin
      par_mem[par_wa] <= par_wd;
    end
    par_rd_q  <= par_mem[cur_d];
    parv_rd_q <= par_valid_q[cur_d];
  end

  assign out_valid_o       = out_valid_q;
  assign cycle_found_o     = cyc_out_q;
  assign edge_was_new_o    = new_out_q;
  assign range_error_o     = rng_out_q;
  assign status_o.cycle    = cycle_q;
  assign status_o.clearing = clr;

endmodule

>>> rtl/core/undirected_graph_cycle_detect.sv
// Request path: clear or out-of-range requests go from IDLE straight to EMIT; other edges pass CHK,
//   and a new edge that is not a self-loop also passes ROWB, FNDA and FNDB (root walks) before EMIT.
// Throughput: one request at a time in the back end; the union-find root walk sets the rate.
// A two-entry queue keeps accepting requests while the back end works, until it fills and stalls the input.
// Reset (rst_ni low, asynchronous): empty graph, no cycle, queue and output empty;
//   row and parent valid bits clear at once, so no clearing pass is needed.
module undirected_graph_cycle_detect (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [9:0] from_node_i,
  input  logic [9:0] to_node_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       cycle_found_o,
  output logic       edge_was_new_o,
  output logic       range_error_o
);
  import ugcd_pkg::*;
  `include "undirected_graph_cycle_detect_assert.svh"

  // Front end: takes each request, sorts it into add edge, clear, or
  // out-of-range edge, and trims the node ids to the graph's index width.
  // The queue holds classified requests until the back end is free.
  ugcd_q_t     q;
  logic        q_pop;
  ugcd_qstat_t q_stat;
  ugcd_bstat_t b_stat;

  ugcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .from_node_i (from_node_i),
    .to_node_i   (to_node_i),
    .q_o         (q),
    .q_pop_i     (q_pop),
    .status_o    (q_stat)
  );

  // Back end: adjacency row memory for the duplicate check (rows written in
  // both directions), parent memory for union-find, sticky cycle flag.
  // Union always hangs the larger root under the smaller, so every walk ends.
  ugcd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_i            (q),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cycle_found_o  (cycle_found_o),
    .edge_was_new_o (edge_was_new_o),
    .range_error_o  (range_error_o),
    .status_o       (b_stat)
  );

  // stall follows the queue's fill level: high exactly when the queue is full
  `UGCD_ASSERT(a_q_stall, in_stall_o == (q_stat.count == QCNT_W'(QDEPTH)), "stall and fill level disagree")
  // an ignored edge is never reported as new
  `UGCD_ASSERT_IMP(a_rng_new, out_valid_o && range_error_o, !edge_was_new_o, "range error with new edge")
  // the cycle flag only drops on a clear request
  `UGCD_ASSERT_IMP(a_cyc_sticky, $fell(b_stat.cycle), $past(b_stat.clearing), "cycle flag lost without clear")

endmodule

>>> dv/undirected_graph_cycle_detect_test.sv
`timescale 1ns / 1ps

// Checks the cycle detector against a predictor kept in step with accepted
// requests. A directed opening covers the special cases, then a long random
// run builds forests, repeats edges and closes cycles, with the graph cleared
// now and then.
import ugcd_pkg::*;

// Expected result of one request.
typedef struct packed {
  logic cycle;
  logic fresh;
  logic range_err;
} graph_flags_t;

class cycle_scoreboard;
  row_t         adj [NODES];
  id_t          parent [NODES];
  logic         cycle_flag;
  graph_flags_t expected_flags [$];
  int unsigned  mismatches;
  int unsigned  checked;

  function new();
    wipe_graph();
    mismatches = 0;
    checked    = 0;
  endfunction

  // Same state as after reset.
  function void wipe_graph();
    for (int i = 0; i < NODES; i++) begin
      adj[i]    = '0;
      parent[i] = id_t'(i);
    end
    cycle_flag = 1'b0;
  endfunction

  // Union-find root walk, bounded at NODES hops.
  function id_t root_of(id_t n);
    id_t p;
    for (int steps = 0; steps < NODES; steps++) begin
      p = parent[n];
      if (p == n) break;
      n = p;
    end
    return n;
  endfunction

  // Advance the predicted graph by one accepted request and queue its flags.
  function void note_request(logic req, logic [9:0] a, logic [9:0] b);
    graph_flags_t f;
    id_t          ia, ib, ra, rb;
    f = '0;
    if (req == REQ_CLEAR) begin
      wipe_graph();
    end else if (a >= NODES || b >= NODES) begin
      f.range_err = 1'b1;
    end else begin
      ia = id_t'(a);
      ib = id_t'(b);
      if (!adj[ia][ib]) begin
        f.fresh    = 1'b1;
        adj[ia][ib] = 1'b1;
        adj[ib][ia] = 1'b1;
        if (ia == ib) begin
          cycle_flag = 1'b1;
        end else begin
          ra = root_of(ia);
          rb = root_of(ib);
          if (ra == rb) cycle_flag = 1'b1;
          else if (ra < rb) parent[rb] = ra;
          else parent[ra] = rb;
        end
      end
    end
    f.cycle = cycle_flag;
    expected_flags = {expected_flags, f};
  endfunction

  function void check_result(logic cyc, logic fresh, logic rerr);
    graph_flags_t f;
    checked++;
    if (expected_flags.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result cycle=%b new=%b range=%b", $realtime, cyc, fresh, rerr);
      return;
    end
    f = expected_flags.pop_front();
    if (cyc !== f.cycle || fresh !== f.fresh || rerr !== f.range_err) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result %0d exp cycle=%b new=%b range=%b got cycle=%b new=%b range=%b",
                 $realtime, checked, f.cycle, f.fresh, f.range_err, cyc, fresh, rerr);
    end
  endfunction

  function int pending();
    return expected_flags.size();
  endfunction
endclass

module undirected_graph_cycle_detect_test;

  logic       clk_i;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       req_type_i   = REQ_ADD;
  logic [9:0] from_node_i  = '0;
  logic [9:0] to_node_i    = '0;
  logic       out_stall_i  = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       cycle_found_o;
  logic       edge_was_new_o;
  logic       range_error_o;

  cycle_scoreboard sb = new();

  // burst bookkeeping for the sender
  int unsigned burst_left = 0;
  // last edge offered, used to make repeats
  logic [9:0]  last_a = '0;
  logic [9:0]  last_b = '0;

  undirected_graph_cycle_detect uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .from_node_i   (from_node_i),
    .to_node_i     (to_node_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cycle_found_o (cycle_found_o),
    .edge_was_new_o(edge_was_new_o),
    .range_error_o (range_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Generous ceiling: even a worst-case run is far shorter.
  initial begin
    #10ms;
    $display("undirected_graph_cycle_detect regression: fail");
    $finish;
  end

  // Offer one request and hold it until accepted. Called at a rising edge.
  // At the end of a burst, valid usually drops for a random gap (with a zero
  // gap it stays high, so valid is not lowered and raised in one step).
  task automatic issue(input logic req, input logic [9:0] a, input logic [9:0] b);
    int unsigned gap;
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    from_node_i <= a;
    to_node_i   <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req, a, b);
    if (req == REQ_ADD) begin
      last_a = a;
      last_b = b;
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stop offering and wait until every outstanding request has its result.
  task automatic drain_results();
    if (in_valid_i) in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Receiver: checks results and stalls on a pattern of its own, switching
  // between free running, light, heavy and alternating stalls. Once, part
  // way through, it holds off for a long stretch so the block backs up.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          hold_done;
    logic        stall_next;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        sb.check_result(cycle_found_o, edge_was_new_o, range_error_o);
      if (!hold_done && sb.checked >= 250) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 128);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        case (mode)
          0: stall_next = 1'b0;
          1: stall_next = ($urandom_range(0, 3) == 0);
          2: stall_next = ($urandom_range(0, 3) != 0);
          default: stall_next = ~out_stall_i;
        endcase
      end
      out_stall_i <= stall_next;
    end
  end

  // Stimulus: directed opening, then the random run.
  initial begin
    int unsigned r;
    int unsigned next_fresh;
    logic [9:0]  a, b, t;
    logic        req;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // plain edge at the id extremes, then repeated both ways round
    issue(REQ_ADD, 10'd0, 10'(NODES - 1));
    issue(REQ_ADD, 10'(NODES - 1), 10'd0);
    issue(REQ_ADD, 10'd0, 10'(NODES - 1));
    // triangle closes a cycle; the flag then sticks
    issue(REQ_ADD, 10'd1, 10'd2);
    issue(REQ_ADD, 10'd2, 10'd3);
    issue(REQ_ADD, 10'd3, 10'd1);
    issue(REQ_ADD, 10'd4, 10'd5);
    // out of range ids leave the flag as it stands
    issue(REQ_ADD, 10'(NODES), 10'd0);
    issue(REQ_ADD, 10'd0, 10'h3FF);
    issue(REQ_ADD, 10'h3FF, 10'h3FF);
    // clear ignores its endpoint fields
    issue(REQ_CLEAR, 10'h3FF, 10'h3FF);
    issue(REQ_ADD, 10'd1, 10'd2);
    issue(REQ_ADD, 10'(NODES), 10'(NODES));
    // self-loop is a cycle on its own, a second one is just a repeat
    issue(REQ_ADD, 10'(NODES - 1), 10'(NODES - 1));
    issue(REQ_ADD, 10'(NODES - 1), 10'(NODES - 1));
    issue(REQ_CLEAR, 10'd0, 10'd0);
    // chain merging components; roots are joined by the lower id
    issue(REQ_ADD, 10'd10, 10'd20);
    issue(REQ_ADD, 10'd30, 10'd40);
    issue(REQ_ADD, 10'd40, 10'd20);
    issue(REQ_ADD, 10'd10, 10'd30);
    issue(REQ_ADD, 10'd0, 10'd0);
    issue(REQ_CLEAR, 10'h2AA, 10'h155);
    issue(REQ_ADD, 10'(NODES - 2), 10'(NODES - 1));
    issue(REQ_CLEAR, 10'h155, 10'h2AA);

    // Random run. The largest share of requests grows a forest one fresh node at a
    // time, so root walks get long before a cycle appears; the rest are repeats,
    // self-loops, arbitrary edges, range errors and clears.
    next_fresh = 1;
    for (int n = 0; n < 800; n++) begin
      if (n == 400) drain_results();
      r   = $urandom_range(0, 99);
      req = REQ_ADD;
      if (r < 3) begin
        req = REQ_CLEAR;
        a   = 10'($urandom);
        b   = 10'($urandom);
        next_fresh = 1;
      end else if (r < 8) begin
        a = 10'($urandom_range(NODES, 1023));
        b = 10'($urandom);
        if ($urandom_range(0, 1)) begin
          t = a; a = b; b = t;
        end
      end else if (r < 18) begin
        a = last_a;
        b = last_b;
        if ($urandom_range(0, 1)) begin
          t = a; a = b; b = t;
        end
      end else if (r < 58 && next_fresh < NODES) begin
        a = 10'(next_fresh);
        b = 10'($urandom_range(0, next_fresh - 1));
        next_fresh++;
        if ($urandom_range(0, 1)) begin
          t = a; a = b; b = t;
        end
      end else if (r < 62) begin
        a = 10'($urandom_range(0, NODES - 1));
        b = a;
      end else begin
        a = 10'($urandom_range(0, NODES - 1));
        b = 10'($urandom_range(0, NODES - 1));
      end
      issue(req, a, b);
    end

    drain_results();
    // room for any stray result to show up
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("undirected_graph_cycle_detect regression: pass");
    end else begin
      $display("undirected_graph_cycle_detect regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ugcd_pkg.sv
rtl/core/ugcd_front.sv
rtl/core/ugcd_back.sv
rtl/core/undirected_graph_cycle_detect.sv
dv/undirected_graph_cycle_detect_test.sv
